// ===== src/ahr_env_pkg.sv =====
package ahr_env_pkg;

    localparam int CHANNELS_DEF = 8;

    localparam int CH_FIELD_W = 3;
    localparam int POS_W      = 32;
    localparam int LVL_W      = 17;
    localparam int ATTACK_W   = 24;
    localparam int HOLD_W     = 25;
    localparam int COEF_W     = 24;
    localparam int PHASE_W    = 2;
    localparam int QUO_W      = 16;
    localparam int DIV_STEPS  = QUO_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 56;
    localparam int M_TUSER_W  = CH_FIELD_W + PHASE_W;

    localparam logic [LVL_W-1:0] UNITY   = 17'h10000;
    localparam logic [POS_W-1:0] POS_MAX = 32'hFFFF_FFFF;

    localparam logic [ATTACK_W-1:0] ATTACK_RST = 24'd480;
    localparam logic [HOLD_W-1:0]   HOLD_RST   = 25'd5280;
    localparam logic [COEF_W-1:0]   COEF_RST   = 24'd16776000;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_END = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF     = 2'd2;

    localparam logic [PHASE_W-1:0] PH_ATTACK  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HOLD    = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } ahr_state_t;

    typedef struct packed {
        logic load;
        logic eval_en;
        logic div_step;
        logic finish;
    } ahr_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } ahr_status_t;

endpackage

// ===== src/ahr_env_ctrl.sv =====
module ahr_env_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  ahr_env_pkg::ahr_status_t status,
    output ahr_env_pkg::ahr_cmd_t    cmd
);

    ahr_env_pkg::ahr_state_t state_reg;
    ahr_env_pkg::ahr_state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ahr_env_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ahr_env_pkg::ST_EVAL;
                end
            end
            ahr_env_pkg::ST_EVAL: begin
                state_next = status.need_div ? ahr_env_pkg::ST_DIV : ahr_env_pkg::ST_DONE;
            end
            ahr_env_pkg::ST_DIV: begin
                if (status.div_last) begin
                    state_next = ahr_env_pkg::ST_DONE;
                end
            end
            ahr_env_pkg::ST_DONE: begin
                if (status.out_free) begin
                    state_next = ahr_env_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ahr_env_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ahr_env_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready     = (state_reg == ahr_env_pkg::ST_IDLE);
    assign cmd.load     = s_tready && s_tvalid;
    assign cmd.eval_en  = (state_reg == ahr_env_pkg::ST_EVAL);
    assign cmd.div_step = (state_reg == ahr_env_pkg::ST_DIV);
    assign cmd.finish   = (state_reg == ahr_env_pkg::ST_DONE) && status.out_free;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && cmd.eval_en))
        else $error("accepted word did not start evaluation");
    a_finish_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> s_tready)
        else $error("controller did not return to idle after finishing");
`endif

endmodule

// ===== src/ahr_env_datapath.sv =====
module ahr_env_datapath #(
    parameter int CHANNELS = ahr_env_pkg::CHANNELS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ahr_env_pkg::ahr_cmd_t                cmd,
    output ahr_env_pkg::ahr_status_t             status,
    input  logic [ahr_env_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [0:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ahr_env_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [ahr_env_pkg::M_TUSER_W-1:0]    m_tuser,
    input  logic                                 cfg_valid,
    input  logic [ahr_env_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ahr_env_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W  = ahr_env_pkg::POS_W;
    localparam int LVL_W  = ahr_env_pkg::LVL_W;
    localparam int WORD_W = POS_W + LVL_W;
    localparam int ATT_W  = ahr_env_pkg::ATTACK_W;
    localparam int PROD_W = LVL_W + ahr_env_pkg::COEF_W;

    logic [ATT_W-1:0]                     attack_reg;
    logic [ahr_env_pkg::HOLD_W-1:0]       hold_end_reg;
    logic [ahr_env_pkg::COEF_W-1:0]       coef_reg;

    logic [WORD_W-1:0]                    mem [CHANNELS];
    logic [CHANNELS-1:0]                  valid_reg;
    logic [WORD_W-1:0]                    rd_word_reg;
    logic                                 rd_valid_reg;
    logic [ahr_env_pkg::CH_FIELD_W-1:0]   ch_reg;
    logic                                 retrig_reg;
    logic [CH_W-1:0]                      rd_addr;
    logic [CH_W-1:0]                      wr_addr;

    logic                                 ch_ok;
    logic [POS_W-1:0]                     cur_pos;
    logic [LVL_W-1:0]                     cur_lvl;
    logic                                 in_attack;
    logic                                 in_hold;
    logic [PROD_W-1:0]                    prod;
    logic [LVL_W-1:0]                     decayed;

    logic                                 ok_reg;
    logic [LVL_W-1:0]                     res_level_reg;
    logic [ahr_env_pkg::PHASE_W-1:0]      res_phase_reg;
    logic [POS_W-1:0]                     res_elapsed_reg;
    logic [POS_W-1:0]                     new_pos_reg;
    logic [LVL_W-1:0]                     new_lvl_reg;

    logic [ATT_W-1:0]                     rem_reg;
    logic [ATT_W-1:0]                     rem_next;
    logic [ahr_env_pkg::QUO_W-1:0]        quo_reg;
    logic [ahr_env_pkg::QUO_W-1:0]        quo_next;
    logic [ahr_env_pkg::CNT_W-1:0]        cnt_reg;
    logic [ATT_W:0]                       trial;
    logic [ATT_W:0]                       diff;
    logic                                 ge;

    logic                                 m_valid_reg;
    logic [ahr_env_pkg::CH_FIELD_W-1:0]   out_ch_reg;
    logic [LVL_W-1:0]                     out_level_reg;
    logic [ahr_env_pkg::PHASE_W-1:0]      out_phase_reg;
    logic [POS_W-1:0]                     out_elapsed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg   <= ahr_env_pkg::ATTACK_RST;
            hold_end_reg <= ahr_env_pkg::HOLD_RST;
            coef_reg     <= ahr_env_pkg::COEF_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                ahr_env_pkg::CFG_ATTACK:   attack_reg   <= cfg_data[ATT_W-1:0];
                ahr_env_pkg::CFG_HOLD_END: hold_end_reg <= cfg_data;
                ahr_env_pkg::CFG_COEF:     coef_reg     <= cfg_data[ahr_env_pkg::COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign rd_addr = CH_W'(s_tdata[ahr_env_pkg::CH_FIELD_W-1:0]);
    assign wr_addr = CH_W'(ch_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rd_word_reg <= mem[rd_addr];
            ch_reg      <= s_tdata[ahr_env_pkg::CH_FIELD_W-1:0];
            retrig_reg  <= s_tuser[0];
        end
        if (cmd.finish && ok_reg) begin
            mem[wr_addr] <= {new_pos_reg, new_lvl_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (cmd.finish && ok_reg) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign ch_ok     = int'(ch_reg) < CHANNELS;
    assign cur_pos   = (retrig_reg || !rd_valid_reg) ? '0 : rd_word_reg[WORD_W-1:LVL_W];
    assign cur_lvl   = (retrig_reg || !rd_valid_reg) ? ahr_env_pkg::UNITY
                                                     : rd_word_reg[LVL_W-1:0];
    assign in_attack = cur_pos < POS_W'(attack_reg);
    assign in_hold   = cur_pos < POS_W'(hold_end_reg);
    assign prod      = PROD_W'(cur_lvl) * PROD_W'(coef_reg);
    assign decayed   = prod[PROD_W-1:ahr_env_pkg::COEF_W];

    assign trial    = {rem_reg, 1'b0};
    assign diff     = trial - {1'b0, attack_reg};
    assign ge       = trial >= {1'b0, attack_reg};
    assign rem_next = ge ? diff[ATT_W-1:0] : trial[ATT_W-1:0];
    assign quo_next = {quo_reg[ahr_env_pkg::QUO_W-2:0], ge};

    always_ff @(posedge aclk) begin
        if (cmd.eval_en) begin
            ok_reg          <= ch_ok;
            res_elapsed_reg <= ch_ok ? cur_pos : '0;
            new_pos_reg     <= (cur_pos == ahr_env_pkg::POS_MAX) ? cur_pos : cur_pos + 1'b1;
            rem_reg         <= cur_pos[ATT_W-1:0];
            quo_reg         <= '0;
            cnt_reg         <= '0;
            if (!ch_ok || in_attack) begin
                res_phase_reg <= ahr_env_pkg::PH_ATTACK;
                res_level_reg <= '0;
                new_lvl_reg   <= ahr_env_pkg::UNITY;
            end else if (in_hold) begin
                res_phase_reg <= ahr_env_pkg::PH_HOLD;
                res_level_reg <= ahr_env_pkg::UNITY;
                new_lvl_reg   <= ahr_env_pkg::UNITY;
            end else begin
                res_phase_reg <= ahr_env_pkg::PH_RELEASE;
                res_level_reg <= decayed;
                new_lvl_reg   <= decayed;
            end
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (status.div_last) begin
                res_level_reg <= LVL_W'(quo_next);
            end
        end
    end

    assign status.need_div = ch_ok && in_attack;
    assign status.div_last = (cnt_reg == ahr_env_pkg::CNT_W'(ahr_env_pkg::DIV_STEPS - 1));
    assign status.out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_ch_reg      <= ch_reg;
            out_level_reg   <= res_level_reg;
            out_phase_reg   <= res_phase_reg;
            out_elapsed_reg <= res_elapsed_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(ahr_env_pkg::M_TDATA_W - POS_W - LVL_W){1'b0}},
                       out_elapsed_reg, out_level_reg};
    assign m_tuser  = {out_phase_reg, out_ch_reg};

`ifndef SYNTHESIS
    a_word_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.finish))
        else $error("result word appeared without a finished item");
    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_phase_reg == ahr_env_pkg::PH_ATTACK ||
                         out_phase_reg == ahr_env_pkg::PH_HOLD ||
                         out_phase_reg == ahr_env_pkg::PH_RELEASE))
        else $error("result word carries an illegal phase");
`endif

endmodule

// ===== src/attack_hold_release_envelope_top.sv =====
// Multichannel attack-hold-release envelope. Each input word advances one channel by one
// sample (retrigger in s_tuser restarts it) and yields exactly one result word. An item
// passes from acceptance through an evaluate state and a finish state in hold, release or
// for a channel beyond CHANNELS, and during attack also through a 16-step radix-2 divider
// that forms the ramp; a pending result word does not stop the next item from being
// accepted, but that item waits before finishing until the word is taken. Channel
// state lives in a small memory whose entries read as position 0 and level 1.0 until
// first written, so no clearing pass follows reset. Registers (reset value): 0 attack
// length in samples (480), 1 end of hold in samples (5280), 2 release coefficient Q0.24
// (16776000); writes are taken every cycle and should be made while the block is idle.
module attack_hold_release_envelope_top #(
    parameter int CHANNELS = ahr_env_pkg::CHANNELS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ahr_env_pkg::S_TDATA_W-1:0]  s_tdata,   // channel[2:0], zeros above
    input  logic [0:0]                         s_tuser,   // retrigger[0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ahr_env_pkg::M_TDATA_W-1:0]  m_tdata,   // level[16:0], elapsed_samples[48:17]
    output logic [ahr_env_pkg::M_TUSER_W-1:0]  m_tuser,   // out_channel[2:0], phase[4:3]
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ahr_env_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ahr_env_pkg::CFG_DATA_W-1:0] cfg_data
);

    ahr_env_pkg::ahr_cmd_t    cmd;
    ahr_env_pkg::ahr_status_t status;

    assign cfg_ready = 1'b1;

    ahr_env_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ahr_env_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
